/* rtl/http_request_tokenizer_assert.svh */
// Assertion macros shared by the tokenizer RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef HTTP_REQUEST_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_TOKENIZER_ASSERT_SVH

// Checked only while out of reset.
`define HTOK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// Checked at every edge, reset included.
`define HTOK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");

`endif

/* rtl/htok_pkg.sv */
// Shared types and constants for the HTTP request tokenizer.
// No dependencies; used by htok_core, htok_out_fifo and the top level.
package htok_pkg;

  localparam int unsigned HDR_CNT_MAX_DEFAULT = 63;

  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [2:0] K_METHOD  = 3'd0;
  localparam logic [2:0] K_URI     = 3'd1;
  localparam logic [2:0] K_VERSION = 3'd2;
  localparam logic [2:0] K_KEY     = 3'd3;
  localparam logic [2:0] K_VALUE   = 3'd4;
  localparam logic [2:0] K_BODY    = 3'd5;
  localparam logic [2:0] K_SEP     = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_kind;
    logic [5:0] header_number;
    logic       last_of_run;
    logic       message_done;
  } res_t;

  // Results produced by one byte: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    res_t       slot0;
    res_t       slot1;
  } push_t;

endpackage

/* rtl/htok_if.sv */
// Handshake channel interfaces of the tokenizer: byte in, token out.
// Standalone; field widths match htok_pkg.
interface htok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, end_of_message, output ready);
endinterface

interface htok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] field_kind;
  logic [5:0] header_number;
  logic       last_of_run;
  logic       message_done;

  modport source (output valid, out_byte, field_kind, header_number, last_of_run,
                  message_done, input ready);
  modport sink (input valid, out_byte, field_kind, header_number, last_of_run,
                message_done, output ready);
endinterface

/* rtl/http_request_tokenizer.sv */
// HTTP request tokenizer, top level.
//
// req_i takes one request byte per transaction with end_of_message set on the
// final byte. res_o gives one token per transaction: the byte, its field kind
// (method, URI, version, header key, header value, body, separator), the
// header line number, last_of_run on the final token of a byte and
// message_done on the final token of the message.
// A byte yields zero, one or two tokens; a colon inside a header key is held
// until the next byte shows whether it splits key from value.
// A taken byte waits in the input register; its tokens are written together
// into the output queue once it has room; a second token follows the first.
// Throughput: one byte per cycle while bytes give one token each and the sink
// takes one per cycle; the output queue drains one token per cycle, so runs of
// two-token bytes are limited by that port.
// Reset clears the parser to the start of a message and empties both queues;
// end_of_message returns the parser to the same state after its last token.
// A stalled sink fills the four-token output queue; req_i.ready then drops
// once the input register holds a byte the queue cannot take.
// Depends on htok_pkg, htok_if, htok_core and htok_out_fifo.
module http_request_tokenizer #(
  parameter int unsigned HEADER_COUNT_MAX = htok_pkg::HDR_CNT_MAX_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htok_in_if.sink    req_i,
  htok_out_if.source res_o
);
  import htok_pkg::*;

  item_t in_q;
  logic  in_valid_q, in_valid_d;
  logic  room;
  logic  fire;
  push_t push;
  res_t  head;

  assign fire        = in_valid_q && room;
  assign req_i.ready = !in_valid_q || room;
  assign in_valid_d  = req_i.valid || (in_valid_q && !room);

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.data_byte      <= req_i.data_byte;
      in_q.end_of_message <= req_i.end_of_message;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= in_valid_d;
    end
  end

  htok_core #(
    .HEADER_COUNT_MAX(HEADER_COUNT_MAX)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .push_o (push)
  );

  htok_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (head)
  );

  assign res_o.out_byte      = head.out_byte;
  assign res_o.field_kind    = head.field_kind;
  assign res_o.header_number = head.header_number;
  assign res_o.last_of_run   = head.last_of_run;
  assign res_o.message_done  = head.message_done;

endmodule

/* rtl/htok_core.sv */
// Parser state and per-byte classification logic of the tokenizer.
// Depends on htok_pkg and http_request_tokenizer_assert.svh.
`include "http_request_tokenizer_assert.svh"

module htok_core #(
  parameter int unsigned HEADER_COUNT_MAX = htok_pkg::HDR_CNT_MAX_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  htok_pkg::item_t item_i,
  output htok_pkg::push_t push_o
);
  import htok_pkg::*;

  localparam int unsigned CntW = $clog2(HEADER_COUNT_MAX + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(HEADER_COUNT_MAX);

  localparam logic [3:0] SEC_METHOD    = 4'd0;
  localparam logic [3:0] SEC_URI_FIRST = 4'd1;
  localparam logic [3:0] SEC_URI       = 4'd2;
  localparam logic [3:0] SEC_VERSION   = 4'd3;
  localparam logic [3:0] SEC_KEY       = 4'd4;
  localparam logic [3:0] SEC_VALUE     = 4'd5;
  localparam logic [3:0] SEC_LF        = 4'd6;
  localparam logic [3:0] SEC_LF_PEND   = 4'd7;
  localparam logic [3:0] SEC_BODY      = 4'd8;

  logic [3:0]      section_q, section_d;
  logic            colon_held_q, colon_held_d;
  logic            line_start_q, line_start_d;
  logic            first_line_q, first_line_d;
  logic            term_lf_q, term_lf_d;
  logic [CntW-1:0] hcount_q, hcount_d;

  logic [7:0] b;
  logic       eom;
  logic [1:0] n;
  res_t       slot [2];

  function automatic res_t mk_res(logic [7:0] ch, logic [2:0] kind, logic [5:0] hn);
    res_t r;
    r.out_byte      = ch;
    r.field_kind    = kind;
    r.header_number = hn;
    r.last_of_run   = 1'b0;
    r.message_done  = 1'b0;
    return r;
  endfunction

  always_comb begin
    b            = item_i.data_byte;
    eom          = item_i.end_of_message;
    section_d    = section_q;
    colon_held_d = colon_held_q;
    line_start_d = line_start_q;
    first_line_d = first_line_q;
    term_lf_d    = term_lf_q;
    hcount_d     = hcount_q;
    n            = 2'd0;
    slot[0]      = '0;
    slot[1]      = '0;

    if (colon_held_d && b == CHAR_SP) begin
      // held colon plus space: both are separators, value starts
      colon_held_d = 1'b0;
      slot[0]   = mk_res(CHAR_COLON, K_SEP, 6'(hcount_d));
      slot[1]   = mk_res(b, K_SEP, 6'(hcount_d));
      n         = 2'd2;
      section_d = SEC_VALUE;
    end else begin
      if (colon_held_d) begin
        // release the held colon as a key byte
        colon_held_d = 1'b0;
        slot[0] = mk_res(CHAR_COLON, K_KEY, 6'(hcount_d));
        n       = 2'd1;
      end
      case (section_d)
        SEC_METHOD, SEC_URI_FIRST, SEC_URI, SEC_VERSION: begin
          if (b == CHAR_CR) begin
            slot[n[0]] = mk_res(b, K_SEP, first_line_d ? 6'd0 : 6'(hcount_d));
            section_d  = SEC_LF;
          end else if (b == CHAR_SP && section_d == SEC_METHOD) begin
            slot[n[0]] = mk_res(b, K_SEP, 6'd0);
            section_d  = SEC_URI_FIRST;
          end else if (b == CHAR_SP && section_d == SEC_URI) begin
            slot[n[0]] = mk_res(b, K_SEP, 6'd0);
            section_d  = SEC_VERSION;
          end else if (section_d == SEC_METHOD) begin
            slot[n[0]] = mk_res(b, K_METHOD, 6'd0);
          end else if (section_d == SEC_VERSION) begin
            slot[n[0]] = mk_res(b, K_VERSION, 6'd0);
          end else begin
            slot[n[0]] = mk_res(b, K_URI, 6'd0);
            section_d  = SEC_URI;
          end
          n            = n + 2'd1;
          line_start_d = 1'b0;
        end
        SEC_KEY: begin
          if (line_start_d && term_lf_d && !first_line_d && b == CHAR_CR) begin
            // empty line after a full terminator: candidate body start
            slot[n[0]]   = mk_res(b, K_SEP, 6'd0);
            n            = n + 2'd1;
            section_d    = SEC_LF_PEND;
            line_start_d = 1'b0;
          end else begin
            if (line_start_d) begin
              if (hcount_d < CntMax) hcount_d = hcount_d + CntW'(1);
              line_start_d = 1'b0;
            end
            if (b == CHAR_CR) begin
              slot[n[0]] = mk_res(b, K_SEP, first_line_d ? 6'd0 : 6'(hcount_d));
              n          = n + 2'd1;
              section_d  = SEC_LF;
            end else if (b == CHAR_COLON) begin
              colon_held_d = 1'b1;
            end else begin
              slot[n[0]] = mk_res(b, K_KEY, 6'(hcount_d));
              n          = n + 2'd1;
            end
          end
        end
        SEC_VALUE: begin
          if (b == CHAR_CR) begin
            slot[n[0]] = mk_res(b, K_SEP, first_line_d ? 6'd0 : 6'(hcount_d));
            section_d  = SEC_LF;
          end else begin
            slot[n[0]] = mk_res(b, K_VALUE, 6'(hcount_d));
          end
          n = n + 2'd1;
        end
        SEC_LF: begin
          slot[n[0]]   = mk_res(b, K_SEP, first_line_d ? 6'd0 : 6'(hcount_d));
          n            = n + 2'd1;
          term_lf_d    = (b == CHAR_LF);
          line_start_d = 1'b1;
          first_line_d = 1'b0;
          section_d    = SEC_KEY;
        end
        SEC_LF_PEND: begin
          if (b == CHAR_LF) begin
            slot[n[0]] = mk_res(b, K_SEP, 6'd0);
            section_d  = SEC_BODY;
          end else begin
            // the empty line was not closed by LF: count it as a header line
            if (hcount_d < CntMax) hcount_d = hcount_d + CntW'(1);
            slot[n[0]]   = mk_res(b, K_SEP, 6'(hcount_d));
            term_lf_d    = 1'b0;
            line_start_d = 1'b1;
            section_d    = SEC_KEY;
          end
          n = n + 2'd1;
        end
        default: begin
          slot[n[0]] = mk_res(b, K_BODY, 6'd0);
          n          = n + 2'd1;
        end
      endcase
    end

    // a colon cannot stay held past the last byte
    if (eom && colon_held_d) begin
      colon_held_d = 1'b0;
      slot[n[0]]   = mk_res(CHAR_COLON, K_KEY, 6'(hcount_d));
      n            = n + 2'd1;
    end

    if (n == 2'd2) begin
      slot[1].last_of_run  = 1'b1;
      slot[1].message_done = eom;
    end else if (n == 2'd1) begin
      slot[0].last_of_run  = 1'b1;
      slot[0].message_done = eom;
    end

    if (eom) begin
      section_d    = SEC_METHOD;
      colon_held_d = 1'b0;
      line_start_d = 1'b1;
      first_line_d = 1'b1;
      term_lf_d    = 1'b0;
      hcount_d     = '0;
    end

    push_o.count = fire_i ? n : 2'd0;
    push_o.slot0 = slot[0];
    push_o.slot1 = slot[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_q    <= SEC_METHOD;
      colon_held_q <= 1'b0;
      line_start_q <= 1'b1;
      first_line_q <= 1'b1;
      term_lf_q    <= 1'b0;
      hcount_q     <= '0;
    end else if (fire_i) begin
      section_q    <= section_d;
      colon_held_q <= colon_held_d;
      line_start_q <= line_start_d;
      first_line_q <= first_line_d;
      term_lf_q    <= term_lf_d;
      hcount_q     <= hcount_d;
    end
  end

  `HTOK_ASSERT_ALWAYS(a_hcount_sat, hcount_q <= CntMax)
  `HTOK_ASSERT(a_colon_in_key, colon_held_q |-> section_q == SEC_KEY)
  `HTOK_ASSERT(a_eom_resets,
      (fire_i && item_i.end_of_message) |=>
      (section_q == SEC_METHOD && hcount_q == '0 && !colon_held_q && first_line_q))
  `HTOK_ASSERT(a_one_result,
      (fire_i && !colon_held_q && section_q != SEC_KEY) |-> push_o.count == 2'd1)

endmodule

/* rtl/htok_out_fifo.sv */
// Four-entry result queue: takes up to two tokens per cycle, hands out one.
// Depends on htok_pkg and http_request_tokenizer_assert.svh.
`include "http_request_tokenizer_assert.svh"

module htok_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  htok_pkg::push_t push_i,
  output logic            room_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output htok_pkg::res_t  res_o
);
  import htok_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  res_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign res_valid_o = (cnt_q != '0);
  assign res_o       = mem[rd_ptr_q];
  assign pop         = res_valid_o && res_ready_i;
  // room for a two-token byte, without counting on a pop
  assign room_o      = (cnt_q <= CntW'(Depth - 2));

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem[wr_ptr_q] <= push_i.slot0;
    if (push_i.count == 2'd2) mem[wr_ptr_q + PtrW'(1)] <= push_i.slot1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `HTOK_ASSERT_ALWAYS(a_no_overflow, cnt_q <= CntW'(Depth))
  `HTOK_ASSERT(a_push_has_room, (push_i.count != 2'd0) |-> room_o)
  `HTOK_ASSERT(a_ptr_gap, PtrW'(wr_ptr_q - rd_ptr_q) == PtrW'(cnt_q))

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for http_request_tokenizer: drives request bytes, predicts every token
// and checks the token stream in order. Needs htok_pkg, htok_if and the tokenizer RTL.
module testbench;
  import htok_pkg::*;

  localparam int unsigned HDR_LIMIT = HDR_CNT_MAX_DEFAULT;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 50;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 300;

  typedef enum logic [3:0] {
    PS_METHOD, PS_URI_FIRST, PS_URI, PS_VERSION, PS_KEY, PS_VALUE, PS_LF, PS_LF_PEND,
    PS_BODY
  } parse_sec_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  htok_in_if  req_if ();
  htok_out_if res_if ();

  http_request_tokenizer #(
    .HEADER_COUNT_MAX(HDR_LIMIT)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  always #2 clk_i = ~clk_i;

  // Parser state of the prediction
  parse_sec_e  tz_sec;
  bit          tz_colon_held;
  bit          tz_line_start;
  bit          tz_first_line;
  bit          tz_term_lf;
  int unsigned tz_hdr_cnt;

  res_t       run_tokens[$];
  res_t       expected_tokens[$];
  logic [7:0] msg_bytes[$];

  int fail_cnt      = 0;
  int items_sent    = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int sink_hold     = 0;
  int cycle_cnt     = 0;

  function automatic void reset_parser();
    tz_sec        = PS_METHOD;
    tz_colon_held = 1'b0;
    tz_line_start = 1'b1;
    tz_first_line = 1'b1;
    tz_term_lf    = 1'b0;
    tz_hdr_cnt    = 0;
  endfunction

  function automatic int unsigned line_num();
    return tz_first_line ? 0 : tz_hdr_cnt;
  endfunction

  function automatic void bump_header_count();
    if (tz_hdr_cnt < HDR_LIMIT) tz_hdr_cnt++;
  endfunction

  function automatic void add_token(logic [7:0] b, logic [2:0] kind, int unsigned hn);
    res_t t;
    t = '0;
    t.out_byte      = b;
    t.field_kind    = kind;
    t.header_number = hn[5:0];
    run_tokens.push_back(t);
  endfunction

  function automatic void end_line(logic [7:0] b);
    add_token(b, K_SEP, line_num());
    tz_sec = PS_LF;
  endfunction

  function automatic void classify_byte(logic [7:0] b);
    case (tz_sec)
      PS_METHOD: begin
        if (b == CHAR_CR) end_line(b);
        else if (b == CHAR_SP) begin
          add_token(b, K_SEP, 0);
          tz_sec = PS_URI_FIRST;
        end else add_token(b, K_METHOD, 0);
        tz_line_start = 1'b0;
      end
      PS_URI_FIRST: begin
        if (b == CHAR_CR) end_line(b);
        else begin
          add_token(b, K_URI, 0);
          tz_sec = PS_URI;
        end
        tz_line_start = 1'b0;
      end
      PS_URI: begin
        if (b == CHAR_CR) end_line(b);
        else if (b == CHAR_SP) begin
          add_token(b, K_SEP, 0);
          tz_sec = PS_VERSION;
        end else add_token(b, K_URI, 0);
        tz_line_start = 1'b0;
      end
      PS_VERSION: begin
        if (b == CHAR_CR) end_line(b);
        else add_token(b, K_VERSION, 0);
        tz_line_start = 1'b0;
      end
      PS_KEY: begin
        // empty line right after a CR LF terminator: candidate body start
        if (tz_line_start && tz_term_lf && !tz_first_line && b == CHAR_CR) begin
          add_token(b, K_SEP, 0);
          tz_sec        = PS_LF_PEND;
          tz_line_start = 1'b0;
        end else begin
          if (tz_line_start) begin
            bump_header_count();
            tz_line_start = 1'b0;
          end
          if (b == CHAR_CR) end_line(b);
          else if (b == CHAR_COLON) tz_colon_held = 1'b1;
          else add_token(b, K_KEY, tz_hdr_cnt);
        end
      end
      PS_VALUE: begin
        if (b == CHAR_CR) end_line(b);
        else add_token(b, K_VALUE, tz_hdr_cnt);
      end
      PS_LF: begin
        add_token(b, K_SEP, line_num());
        tz_term_lf    = (b == CHAR_LF);
        tz_line_start = 1'b1;
        tz_first_line = 1'b0;
        tz_sec        = PS_KEY;
      end
      PS_LF_PEND: begin
        if (b == CHAR_LF) begin
          add_token(b, K_SEP, 0);
          tz_sec = PS_BODY;
        end else begin
          // no LF: the empty line was a header line after all
          bump_header_count();
          add_token(b, K_SEP, tz_hdr_cnt);
          tz_term_lf    = 1'b0;
          tz_line_start = 1'b1;
          tz_sec        = PS_KEY;
        end
      end
      default: add_token(b, K_BODY, 0);
    endcase
  endfunction

  // Predict the tokens of one accepted byte and queue them.
  function automatic void tokenize_byte(logic [7:0] b, logic eom);
    res_t t;
    run_tokens.delete();
    if (tz_colon_held) begin
      tz_colon_held = 1'b0;
      if (b == CHAR_SP) begin
        add_token(CHAR_COLON, K_SEP, tz_hdr_cnt);
        add_token(b, K_SEP, tz_hdr_cnt);
        tz_sec = PS_VALUE;
      end else begin
        add_token(CHAR_COLON, K_KEY, tz_hdr_cnt);
        classify_byte(b);
      end
    end else begin
      classify_byte(b);
    end
    // a colon on the last byte cannot wait for a successor
    if (eom && tz_colon_held) begin
      tz_colon_held = 1'b0;
      add_token(CHAR_COLON, K_KEY, tz_hdr_cnt);
    end
    if (run_tokens.size() > 0) begin
      t = run_tokens.pop_back();
      t.last_of_run  = 1'b1;
      t.message_done = eom;
      run_tokens.push_back(t);
    end
    foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
    if (eom) reset_parser();
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] text_byte(logic [7:0] ex0, logic [7:0] ex1);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ex0 || b == ex1);
    return b;
  endfunction

  function automatic logic [7:0] any_byte();
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return CHAR_SP;
      1: return CHAR_COLON;
      2: return CHAR_CR;
      default: return CHAR_LF;
    endcase
  endfunction

  function automatic logic [7:0] terminator_byte();
    return ($urandom_range(0, 7) == 0) ? text_byte(CHAR_LF, CHAR_LF) : CHAR_LF;
  endfunction

  // Mostly well-formed request with random content; max_len bounds each field.
  function automatic void build_request(int n_hdr, int max_len);
    int  n;
    bit  has_colon;
    msg_bytes.delete();
    n = $urandom_range(1, max_len);
    repeat (n) msg_bytes.push_back(text_byte(CHAR_SP, CHAR_CR));
    msg_bytes.push_back(CHAR_SP);
    msg_bytes.push_back(text_byte(CHAR_CR, CHAR_CR));
    n = $urandom_range(0, max_len);
    repeat (n) msg_bytes.push_back(text_byte(CHAR_SP, CHAR_CR));
    msg_bytes.push_back(CHAR_SP);
    n = $urandom_range(0, max_len);
    repeat (n) msg_bytes.push_back(text_byte(CHAR_CR, CHAR_CR));
    msg_bytes.push_back(CHAR_CR);
    msg_bytes.push_back(terminator_byte());
    repeat (n_hdr) begin
      n = $urandom_range(0, max_len);
      has_colon = (n == 0) || ($urandom_range(0, 3) != 0);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) msg_bytes.push_back(CHAR_COLON);
        else msg_bytes.push_back(text_byte(CHAR_COLON, CHAR_CR));
      end
      if (has_colon) begin
        msg_bytes.push_back(CHAR_COLON);
        msg_bytes.push_back(CHAR_SP);
        n = $urandom_range(0, max_len);
        repeat (n) msg_bytes.push_back(text_byte(CHAR_CR, CHAR_CR));
      end
      msg_bytes.push_back(CHAR_CR);
      msg_bytes.push_back(terminator_byte());
    end
    msg_bytes.push_back(CHAR_CR);
    msg_bytes.push_back(terminator_byte());
    n = $urandom_range(0, max_len);
    repeat (n) msg_bytes.push_back(any_byte());
  endfunction

  task automatic send_byte(logic [7:0] b, logic eom);
    int gap;
    gap = ($urandom_range(0, 99) < src_idle_pct) ? gap_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.data_byte      <= b;
    req_if.end_of_message <= eom;
    do @(posedge clk_i); while (!req_if.ready);
    tokenize_byte(b, eom);
    items_sent++;
  endtask

  task automatic send_msg(bit close);
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], close && (i == msg_bytes.size() - 1));
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_message_edges();
    src_idle_pct  = 30;
    sink_idle_pct = 30;
    // opens with an empty request line, then goes straight to the body
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // space right after the method is URI; message closes with no line end
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_SP, 1'b0);
    send_byte(CHAR_SP, 1'b0);
    send_byte(CHAR_SP, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drain();
  endtask

  task automatic test_header_lines();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_byte("M", 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte("x", 1'b0);       // terminator without LF
    send_byte(CHAR_CR, 1'b0);   // empty header line
    send_byte(CHAR_LF, 1'b0);
    send_byte("k", 1'b0);
    send_byte(CHAR_COLON, 1'b0);
    send_byte(CHAR_SP, 1'b0);   // held colon splits key and value
    send_byte("v", 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_CR, 1'b0);   // empty line, then no LF
    send_byte("q", 1'b0);
    send_byte(CHAR_COLON, 1'b0);
    send_byte("b", 1'b0);       // held colon released as key byte
    send_byte(CHAR_COLON, 1'b1);
    wait_drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sink_hold     = HOLD_CYCLES;
    build_request(3, 8);
    send_msg(1'b1);
    wait_drain();
  endtask

  task automatic test_header_saturation();
    src_idle_pct  = 10;
    sink_idle_pct = 10;
    build_request(int'(HDR_LIMIT) + 5, 1);
    send_msg(1'b1);
    wait_drain();
  endtask

  task automatic test_random_requests();
    int first;
    int r;
    int cut;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: src_idle_pct = 0;
        1: src_idle_pct = 20;
        default: src_idle_pct = 60;
      endcase
      case ($urandom_range(0, 2))
        0: sink_idle_pct = 0;
        1: sink_idle_pct = 20;
        default: sink_idle_pct = 60;
      endcase
      r = $urandom_range(0, 99);
      if (r < 80) begin
        build_request($urandom_range(0, 4), 6);
      end else begin
        msg_bytes.delete();
        repeat ($urandom_range(1, 20)) msg_bytes.push_back(any_byte());
      end
      // cut some requests short
      if (r >= 65 && r < 80) begin
        cut = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
      send_msg(r < 95);
    end
  endtask

  // Sink side: random stalls plus the long hold-off requested by a test.
  initial begin
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        res_if.ready <= 1'b0;
        sink_hold--;
      end else if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < sink_idle_pct) stall = gap_len();
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ERROR: %s expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t ERROR: token byte %0h kind %0d expected none", $time,
                 res_if.out_byte, res_if.field_kind);
        fail_cnt++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(res_if.out_byte));
        check_field("field_kind", 32'(want.field_kind), 32'(res_if.field_kind));
        check_field("header_number", 32'(want.header_number),
                    32'(res_if.header_number));
        check_field("last_of_run", 32'(want.last_of_run), 32'(res_if.last_of_run));
        check_field("message_done", 32'(want.message_done), 32'(res_if.message_done));
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("http_request_tokenizer: mismatch");
    $finish;
  end

  initial begin
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.data_byte      = 8'h00;
    req_if.end_of_message = 1'b0;
    reset_parser();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_message_edges();
    test_header_lines();
    test_backpressure();
    test_header_saturation();
    test_random_requests();

    sink_idle_pct = 0;
    wait_drain();
    if (fail_cnt == 0) begin
      $display("http_request_tokenizer: match");
    end else begin
      $display("http_request_tokenizer: mismatch");
    end
    $finish;
  end

endmodule

/* http_request_tokenizer.f */
+incdir+rtl
rtl/htok_pkg.sv
rtl/htok_if.sv
rtl/htok_core.sv
rtl/htok_out_fifo.sv
rtl/http_request_tokenizer.sv
tb/sv/testbench.sv
